@@ src/q8dot_pkg.sv @@
// q8dot_pkg: shared constants, types and state codes of the q8_0 block dot accumulator
// used by q8dot_lane, q8dot_round and q8_0_block_dot_accumulate
// no dependencies
package q8dot_pkg;

    localparam int BLOCK_ELEMENTS = 32;
    localparam int LANES          = 4;
    localparam int LANE_ELEMS     = BLOCK_ELEMENTS / LANES;

    // -128 * -128 = 16384 still fits a signed 16-bit product
    localparam int PROD_W      = 16;
    localparam int LANE_SUM_W  = 19;
    localparam int DOT_W       = 21;
    localparam int DOT_MAG_W   = 20;
    localparam int SCALE_MAG_W = 35;
    localparam int P_MAG_W     = 44;
    localparam int WIN_W       = 72;
    localparam int MAG_W       = WIN_W + 1;
    localparam int EXP_W       = 11;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

    typedef logic signed [EXP_W-1:0] exp_t;

    // exact magnitude with the weight of its bit 0, handed to the rounding unit
    typedef struct packed {
        logic              sign;
        exp_t              lsb_exp;
        logic [MAG_W-1:0]  mag;
    } rnd_in_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MERGE,
        ST_SNORM,
        ST_SRND,
        ST_PROD,
        ST_ALIGN,
        ST_ADD,
        ST_NORM,
        ST_FIN
    } state_t;

endpackage

@@ src/q8dot_lane.sv @@
// q8dot_lane: one lane of the block dot product, eight int8 products summed and registered
// depends on q8dot_pkg
module q8dot_lane (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic [63:0]                            weight,
    input  logic [63:0]                            act,
    output logic signed [q8dot_pkg::LANE_SUM_W-1:0] part_sum
);
    import q8dot_pkg::*;

    logic signed [LANE_SUM_W-1:0] part_sum_reg;
    logic signed [LANE_SUM_W-1:0] part_sum_next;

    always_comb
    begin
        logic signed [PROD_W-1:0] w_ext;
        logic signed [PROD_W-1:0] a_ext;
        logic signed [PROD_W-1:0] prod;
        part_sum_next = '0;
        for (int i = 0; i < LANE_ELEMS; i++)
        begin
            w_ext = {{(PROD_W-8){weight[8*i+7]}}, weight[8*i +: 8]};
            a_ext = {{(PROD_W-8){act[8*i+7]}}, act[8*i +: 8]};
            prod  = w_ext * a_ext;
            part_sum_next = part_sum_next + LANE_SUM_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            part_sum_reg <= part_sum_next;
        end
    end

    assign part_sum = part_sum_reg;

endmodule

@@ src/q8dot_round.sv @@
// q8dot_round: shared two-step rounding unit, exact magnitude to fp32 with round to nearest even
// first step finds the leading one and the shift, second shifts, rounds and packs; uses q8dot_pkg
module q8dot_round (
    input  logic                 clk,
    input  logic                 load,
    input  q8dot_pkg::rnd_in_t   rnd_in,
    output logic [31:0]          result
);
    import q8dot_pkg::*;

    localparam int EXT_W = MAG_W + 24;

    logic [MAG_W-1:0] mag_reg;
    logic [6:0]       shift_reg;
    logic [6:0]       shift_next;
    logic [7:0]       expf_reg;
    logic [7:0]       expf_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             zero_reg;
    logic             sign_reg;

    logic [6:0]       msb_idx;
    exp_t             msb_exp;
    exp_t             shift_full;
    logic             is_normal;

    always_comb
    begin
        msb_idx = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (rnd_in.mag[i])
            begin
                msb_idx = 7'(i);
            end
        end
        msb_exp    = rnd_in.lsb_exp + $signed({4'b0, msb_idx});
        is_normal  = msb_exp >= -11'sd126;
        // subnormal results keep their lsb at 2^-149
        shift_full = is_normal ? $signed({4'b0, msb_idx}) : (-11'sd126 - rnd_in.lsb_exp);
        shift_next = (shift_full > 11'sd97) ? 7'd97 : shift_full[6:0];
        ovf_next   = is_normal && (msb_exp >= 11'sd128);
        expf_next  = (is_normal && !ovf_next) ? 8'(msb_exp + 11'sd127) : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg   <= rnd_in.mag;
            shift_reg <= shift_next;
            expf_reg  <= expf_next;
            ovf_reg   <= ovf_next;
            zero_reg  <= (rnd_in.mag == '0);
            sign_reg  <= rnd_in.sign;
        end
    end

    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] shifted;
    logic             sticky;
    logic             round_up;
    logic [30:0]      body;

    always_comb
    begin
        ext      = {mag_reg, 24'b0};
        shifted  = ext >> shift_reg;
        sticky   = (ext << (7'd97 - shift_reg)) != '0;
        round_up = shifted[0] && (sticky || shifted[1]);
        // carry out of the mantissa bumps the exponent, up to infinity
        body     = {expf_reg, shifted[23:1]} + 31'(round_up);
        priority if (zero_reg)
        begin
            result = {sign_reg, 31'b0};
        end
        else if (ovf_reg)
        begin
            result = {sign_reg, 8'hFF, 23'b0};
        end
        else
        begin
            result = {sign_reg, body};
        end
    end

endmodule

@@ src/q8_0_block_dot_accumulate.sv @@
// q8_0 block dot accumulator: accepts a beat while idle, one result beat per last block
// one block at a time: the block walks lane merge, scale rounding, scaled
// product, alignment, add and final rounding through one shared rounding unit before the
// accumulator is written back for the next block
// reset: accumulator is +0, no result pending, input stall low
// depends on q8dot_pkg, q8dot_lane, q8dot_round
module q8_0_block_dot_accumulate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] weight_lo,
    input  logic [63:0] weight_mid_lo,
    input  logic [63:0] weight_mid_hi,
    input  logic [63:0] weight_hi,
    input  logic [63:0] act_lo,
    input  logic [63:0] act_mid_lo,
    input  logic [63:0] act_mid_hi,
    input  logic [63:0] act_hi,
    input  logic [15:0] weight_scale,
    input  logic [31:0] act_scale,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] dot_result
);
    import q8dot_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // lanes
    logic [63:0] w_words [LANES];
    logic [63:0] a_words [LANES];
    logic signed [LANE_SUM_W-1:0] lane_sum [LANES];

    assign w_words[0] = weight_lo;
    assign w_words[1] = weight_mid_lo;
    assign w_words[2] = weight_mid_hi;
    assign w_words[3] = weight_hi;
    assign a_words[0] = act_lo;
    assign a_words[1] = act_mid_lo;
    assign a_words[2] = act_mid_hi;
    assign a_words[3] = act_hi;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        q8dot_lane u_lane (
            .clk      (clk),
            .load     (accept),
            .weight   (w_words[g]),
            .act      (a_words[g]),
            .part_sum (lane_sum[g])
        );
    end

    // beat capture
    logic [15:0] ws_reg;
    logic [31:0] as_reg;
    logic        last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ws_reg   <= weight_scale;
            as_reg   <= act_scale;
            last_reg <= last_block;
        end
    end

    // merge lanes and multiply scale significands
    logic signed [DOT_W-1:0] dot_reg;
    logic signed [DOT_W-1:0] dot_next;
    logic [SCALE_MAG_W-1:0]  sp_mag_reg;
    logic [SCALE_MAG_W-1:0]  sp_mag_next;
    exp_t                    sp_lsb_reg;
    exp_t                    sp_lsb_next;
    logic                    sp_sign_reg;
    logic                    s_nan_reg;
    logic                    s_nan_next;
    logic                    s_inf_reg;
    logic                    s_inf_next;

    always_comb
    begin
        logic [4:0]  h_e;
        logic [4:0]  h_ep;
        logic [10:0] h_sig;
        logic [7:0]  a_e;
        logic [7:0]  a_ep;
        logic [23:0] a_sig;
        logic        h_nan;
        logic        h_inf;
        logic        a_nan;
        logic        a_inf;
        logic        h_zero;
        logic        a_zero;
        dot_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            dot_next = dot_next + DOT_W'(lane_sum[i]);
        end
        h_e    = ws_reg[14:10];
        h_ep   = (h_e == 5'd0) ? 5'd1 : h_e;
        h_sig  = {h_e != 5'd0, ws_reg[9:0]};
        a_e    = as_reg[30:23];
        a_ep   = (a_e == 8'd0) ? 8'd1 : a_e;
        a_sig  = {a_e != 8'd0, as_reg[22:0]};
        h_nan  = (h_e == 5'h1F) && (ws_reg[9:0] != '0);
        h_inf  = (h_e == 5'h1F) && (ws_reg[9:0] == '0);
        a_nan  = (a_e == 8'hFF) && (as_reg[22:0] != '0);
        a_inf  = (a_e == 8'hFF) && (as_reg[22:0] == '0);
        h_zero = (ws_reg[14:0] == '0);
        a_zero = (as_reg[30:0] == '0);
        sp_mag_next = SCALE_MAG_W'(h_sig) * SCALE_MAG_W'(a_sig);
        sp_lsb_next = $signed({6'b0, h_ep}) + $signed({3'b0, a_ep}) - 11'sd175;
        s_nan_next  = h_nan || a_nan || (h_inf && a_zero) || (a_inf && h_zero);
        s_inf_next  = (h_inf || a_inf) && !s_nan_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MERGE)
        begin
            dot_reg     <= dot_next;
            sp_mag_reg  <= sp_mag_next;
            sp_lsb_reg  <= sp_lsb_next;
            sp_sign_reg <= ws_reg[15] ^ as_reg[31];
            s_nan_reg   <= s_nan_next;
            s_inf_reg   <= s_inf_next;
        end
    end

    // shared rounding unit
    rnd_in_t     rnd_in;
    logic        rnd_load;
    logic [31:0] rnd_result;

    logic [MAG_W-1:0] sum_mag_reg;
    logic             sum_sign_reg;
    exp_t             sum_lsb_reg;

    always_comb
    begin
        if (state_reg == ST_SNORM)
        begin
            rnd_in = '{sign: sp_sign_reg, lsb_exp: sp_lsb_reg, mag: MAG_W'(sp_mag_reg)};
        end
        else
        begin
            rnd_in = '{sign: sum_sign_reg, lsb_exp: sum_lsb_reg, mag: sum_mag_reg};
        end
    end

    assign rnd_load = (state_reg == ST_SNORM) || (state_reg == ST_NORM);

    q8dot_round u_round (
        .clk    (clk),
        .load   (rnd_load),
        .rnd_in (rnd_in),
        .result (rnd_result)
    );

    // rounded scale
    logic [31:0] scale_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SRND)
        begin
            if (s_nan_reg)
            begin
                scale_reg <= CANON_NAN;
            end
            else if (s_inf_reg)
            begin
                scale_reg <= {sp_sign_reg, 8'hFF, 23'b0};
            end
            else
            begin
                scale_reg <= rnd_result;
            end
        end
    end

    // scaled product and special cases
    logic [31:0]        acc_reg;
    logic [31:0]        acc_next;
    logic [P_MAG_W-1:0] p_mag_reg;
    logic [P_MAG_W-1:0] p_mag_next;
    logic               p_sign_reg;
    logic               p_sign_next;
    exp_t               ty_reg;
    exp_t               ty_next;
    logic               spec_hit_reg;
    logic               spec_hit_next;
    logic [31:0]        spec_val_reg;
    logic [31:0]        spec_val_next;

    always_comb
    begin
        logic [7:0]           s_e;
        logic [7:0]           s_ep;
        logic [23:0]          s_sig;
        logic                 dot_neg;
        logic [DOT_W-1:0]     dot_abs;
        logic                 sc_nan;
        logic                 sc_inf;
        logic                 acc_nan;
        logic                 acc_inf;
        logic                 acc_zero;
        logic                 p_zero;
        s_e      = scale_reg[30:23];
        s_ep     = (s_e == 8'd0) ? 8'd1 : s_e;
        s_sig    = {s_e != 8'd0, scale_reg[22:0]};
        dot_neg  = dot_reg[DOT_W-1];
        dot_abs  = dot_neg ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
        p_mag_next  = P_MAG_W'(s_sig) * P_MAG_W'(dot_abs[DOT_MAG_W-1:0]);
        p_sign_next = scale_reg[31] ^ dot_neg;
        ty_next     = $signed({3'b0, s_ep}) - 11'sd106;
        sc_nan   = (s_e == 8'hFF) && (scale_reg[22:0] != '0);
        sc_inf   = (s_e == 8'hFF) && (scale_reg[22:0] == '0);
        acc_nan  = (acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] != '0);
        acc_inf  = (acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] == '0);
        acc_zero = (acc_reg[30:0] == '0);
        p_zero   = (scale_reg[30:0] == '0) || (dot_reg == '0);
        spec_hit_next = 1'b1;
        spec_val_next = CANON_NAN;
        priority if (acc_nan || sc_nan)
        begin
            spec_val_next = CANON_NAN;
        end
        else if (sc_inf)
        begin
            // inf times zero, or inf minus inf
            if ((dot_reg == '0) || (acc_inf && (acc_reg[31] != p_sign_next)))
            begin
                spec_val_next = CANON_NAN;
            end
            else
            begin
                spec_val_next = {p_sign_next, 8'hFF, 23'b0};
            end
        end
        else if (acc_inf)
        begin
            spec_val_next = acc_reg;
        end
        else if (p_zero)
        begin
            spec_val_next = acc_zero ? {acc_reg[31] & p_sign_next, 31'b0} : acc_reg;
        end
        else
        begin
            spec_hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PROD)
        begin
            p_mag_reg    <= p_mag_next;
            p_sign_reg   <= p_sign_next;
            ty_reg       <= ty_next;
            spec_hit_reg <= spec_hit_next;
            spec_val_reg <= spec_val_next;
        end
    end

    // alignment of accumulator and product in one window, shifted-out bits jammed into bit 0
    logic [WIN_W-1:0] big_reg;
    logic [WIN_W-1:0] big_next;
    logic [WIN_W-1:0] small_reg;
    logic [WIN_W-1:0] small_next;
    logic             sub_reg;
    logic             bsign_reg;
    logic             bsign_next;
    exp_t             tbig_reg;
    exp_t             tbig_next;

    always_comb
    begin
        logic [7:0]       x_ep;
        logic [23:0]      x_sig;
        exp_t             tx;
        exp_t             exp_gap;
        logic             x_big;
        logic [6:0]       d;
        logic [WIN_W-1:0] x_field;
        logic [WIN_W-1:0] p_field;
        logic [WIN_W-1:0] small_full;
        logic             sticky;
        x_ep    = (acc_reg[30:23] == 8'd0) ? 8'd1 : acc_reg[30:23];
        x_sig   = {acc_reg[30:23] != 8'd0, acc_reg[22:0]};
        tx      = $signed({3'b0, x_ep}) - 11'sd126;
        x_big   = (acc_reg[30:0] != '0) && (tx >= ty_reg);
        exp_gap = x_big ? (tx - ty_reg) : (ty_reg - tx);
        priority if (exp_gap < 11'sd0)
        begin
            d = 7'd0;
        end
        else if (exp_gap > 11'sd72)
        begin
            d = 7'd72;
        end
        else
        begin
            d = exp_gap[6:0];
        end
        x_field    = {x_sig, 48'b0};
        p_field    = {p_mag_reg, 28'b0};
        big_next   = x_big ? x_field : p_field;
        small_full = x_big ? p_field : x_field;
        sticky     = (small_full << (7'd72 - d)) != '0;
        small_next = (small_full >> d) | {{(WIN_W-1){1'b0}}, sticky};
        bsign_next = x_big ? acc_reg[31] : p_sign_reg;
        tbig_next  = x_big ? tx : ty_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ALIGN)
        begin
            big_reg   <= big_next;
            small_reg <= small_next;
            sub_reg   <= acc_reg[31] != p_sign_reg;
            bsign_reg <= bsign_next;
            tbig_reg  <= tbig_next;
        end
    end

    // add or subtract, magnitude and sign
    always_ff @(posedge clk)
    begin
        logic [MAG_W:0]   raw;
        logic             neg;
        logic [MAG_W-1:0] mag;
        if (state_reg == ST_ADD)
        begin
            if (sub_reg)
            begin
                raw = {2'b0, big_reg} - {2'b0, small_reg};
            end
            else
            begin
                raw = {2'b0, big_reg} + {2'b0, small_reg};
            end
            neg = sub_reg && raw[MAG_W];
            mag = neg ? MAG_W'(-raw) : raw[MAG_W-1:0];
            sum_mag_reg  <= mag;
            // exact cancellation gives +0
            sum_sign_reg <= (mag == '0) ? 1'b0 : (bsign_reg ^ neg);
            sum_lsb_reg  <= tbig_reg - 11'sd72;
        end
    end

    // write back and result
    logic        fin_blocked;
    logic        fin_done;
    logic [31:0] fin_val;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] dot_result_reg;

    assign fin_blocked = last_reg && out_valid_reg && out_stall;
    assign fin_done    = (state_reg == ST_FIN) && !fin_blocked;
    assign fin_val     = spec_hit_reg ? spec_val_reg : rnd_result;

    always_comb
    begin
        acc_next = acc_reg;
        if (fin_done)
        begin
            acc_next = last_reg ? POS_ZERO : fin_val;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (fin_done && last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_done && last_reg)
        begin
            dot_result_reg <= fin_val;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = accept ? ST_MERGE : ST_IDLE;
            ST_MERGE: state_next = ST_SNORM;
            ST_SNORM: state_next = ST_SRND;
            ST_SRND:  state_next = ST_PROD;
            ST_PROD:  state_next = ST_ALIGN;
            ST_ALIGN: state_next = ST_ADD;
            ST_ADD:   state_next = ST_NORM;
            ST_NORM:  state_next = ST_FIN;
            ST_FIN:   state_next = fin_blocked ? ST_FIN : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= POS_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dot_result = dot_result_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MERGE)
        else $error("accepted beat did not start the merge step");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN) && $past(last_reg))
        else $error("result beat raised outside the write-back of a last block");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_done && last_reg) |=> acc_reg == POS_ZERO)
        else $error("accumulator not cleared after a last block");

    a_acc_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        ((acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] != '0)) |-> acc_reg == CANON_NAN)
        else $error("accumulator holds a non-canonical nan");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(dot_result_reg))
        else $error("pending result beat overwritten");

endmodule

@@ tb/tb_q8_0_block_dot_accumulate.sv @@
// testbench for q8_0_block_dot_accumulate: random and directed q8_0 block pairs
// checked against a bit-exact fp32 prediction of the scaled fused accumulation
// depends on q8dot_pkg and the q8_0_block_dot_accumulate rtl
`timescale 1ns / 100ps

module tb_q8_0_block_dot_accumulate;

    import q8dot_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [3:0][63:0] w;
        logic [3:0][63:0] a;
        logic [15:0]      hscale;
        logic [31:0]      ascale;
        logic             last;
    } block_pair_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] weight_lo, weight_mid_lo, weight_mid_hi, weight_hi;
    logic [63:0] act_lo, act_mid_lo, act_mid_hi, act_hi;
    logic [15:0] weight_scale;
    logic [31:0] act_scale;
    logic        last_block;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] dot_result;

    logic [31:0] acc_model;
    logic [31:0] expected_sums[$];
    int          fail_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          stall_pct;

    q8_0_block_dot_accumulate i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .weight_lo     (weight_lo),
        .weight_mid_lo (weight_mid_lo),
        .weight_mid_hi (weight_mid_hi),
        .weight_hi     (weight_hi),
        .act_lo        (act_lo),
        .act_mid_lo    (act_mid_lo),
        .act_mid_hi    (act_mid_hi),
        .act_hi        (act_hi),
        .weight_scale  (weight_scale),
        .act_scale     (act_scale),
        .last_block    (last_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .dot_result    (dot_result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- fp helpers ----------------

    function automatic logic [31:0] half_to_single(logic [15:0] h);
        logic [10:0] m;
        int          ex;
        m  = {1'b0, h[9:0]};
        ex = h[14:10];
        if (ex == 31)
            return {h[15], 8'hFF, h[9:0], 13'b0};
        if (ex == 0)
        begin
            if (m == 0)
                return {h[15], 31'b0};
            ex = 1;
            while (!m[10])
            begin
                m = m << 1;
                ex--;
            end
        end
        return {h[15], 8'(ex + 112), m[9:0], 13'b0};
    endfunction

    function automatic real single_to_real(logic [31:0] b);
        logic [63:0] d;
        logic [23:0] m;
        int          ex;
        m  = {1'b0, b[22:0]};
        ex = b[30:23];
        if (ex == 255)
            d = {b[31], 11'h7FF, b[22:0], 29'b0};
        else if (ex == 0 && m == 0)
            d = {b[31], 63'b0};
        else
        begin
            if (ex == 0)
            begin
                ex = 1;
                while (!m[23])
                begin
                    m = m << 1;
                    ex--;
                end
            end
            d = {b[31], 11'(ex + 896), m[22:0], 29'b0};
        end
        return $bitstoreal(d);
    endfunction

    // double to single, round to nearest even, subnormals kept
    function automatic logic [31:0] real_to_single(real x);
        logic [63:0]  d;
        logic [52:0]  sig;
        logic [116:0] ext;
        logic [52:0]  q;
        logic         guard;
        logic         sticky;
        int           e;
        int           ue;
        int           sh;
        d   = $realtobits(x);
        e   = d[62:52];
        sig = {1'b1, d[51:0]};
        if (e == 2047)
            return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'b0};
        if (e == 0)
            return {d[63], 31'b0};
        ue = e - 1023;
        sh = (ue >= -126) ? 29 : 29 + (-126 - ue);
        if (sh > 60)
            return {d[63], 31'b0};
        ext    = {sig, 64'b0} >> sh;
        q      = ext[116:64];
        guard  = ext[63];
        sticky = |ext[62:0];
        if (guard && (sticky || q[0]))
            q = q + 1;
        if (ue < -126)
            return {d[63], q[30:0]};
        if (q[24])
        begin
            q = q >> 1;
            ue++;
        end
        if (ue > 127)
            return {d[63], 8'hFF, 23'b0};
        return {d[63], 8'(ue + 127), q[22:0]};
    endfunction

    function automatic int block_dot(block_pair_t b);
        int             sum;
        logic signed [7:0] wv;
        logic signed [7:0] av;
        sum = 0;
        for (int i = 0; i < BLOCK_ELEMENTS; i++)
        begin
            wv  = b.w[i / 8][8 * (i % 8) +: 8];
            av  = b.a[i / 8][8 * (i % 8) +: 8];
            sum += int'(wv) * int'(av);
        end
        return sum;
    endfunction

    // scaled fused accumulate of one block, pushes the sum on a last block
    task automatic accumulate_block(block_pair_t b);
        logic [31:0] scale_bits;
        logic [31:0] r;
        logic [63:0] sb;
        real         acc_r, prod, s, bb, err;
        scale_bits = real_to_single(single_to_real(half_to_single(b.hscale))
                                    * single_to_real(b.ascale));
        prod  = single_to_real(scale_bits) * real'(block_dot(b));
        acc_r = single_to_real(acc_model);
        s     = acc_r + prod;
        if (s - s == 0.0)
        begin
            bb  = s - acc_r;
            err = (acc_r - (s - bb)) + (prod - bb);
            // round to odd so the later single rounding is correct
            if (err != 0.0)
            begin
                sb = $realtobits(s);
                if (sb[0] == 1'b0)
                begin
                    if ((err > 0.0) == (s > 0.0))
                        sb = sb + 1;
                    else
                        sb = sb - 1;
                    s = $bitstoreal(sb);
                end
            end
        end
        r = real_to_single(s);
        if (r[30:23] == 8'hFF && r[22:0] != 0)
            r = CANON_NAN;
        acc_model = r;
        if (b.last)
        begin
            expected_sums.push_back(acc_model);
            acc_model = POS_ZERO;
        end
    endtask

    // ---------------- driving ----------------

    task automatic send_block(block_pair_t b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        {weight_hi, weight_mid_hi, weight_mid_lo, weight_lo} <= b.w;
        {act_hi, act_mid_hi, act_mid_lo, act_lo}             <= b.a;
        weight_scale <= b.hscale;
        act_scale    <= b.ascale;
        last_block   <= b.last;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accumulate_block(b);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                $display("%0t unexpected dot_result: expected none, actual %h",
                         $time, dot_result);
                fail_count++;
            end
            else
            begin
                if (dot_result !== expected_sums[0])
                begin
                    $display("%0t dot_result mismatch: expected %h, actual %h",
                             $time, expected_sums[0], dot_result);
                    fail_count++;
                end
                void'(expected_sums.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic block_pair_t rand_block(logic last);
        block_pair_t b;
        int          pick;
        for (int i = 0; i < 4; i++)
        begin
            b.w[i] = rand_word();
            b.a[i] = rand_word();
        end
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            b.w = {32{8'h80}};
            b.a = {32{8'h80}};
        end
        else if (pick < 6)
            b.a = {32{8'h7F}};
        if ($urandom_range(9) == 0)
            b.hscale = $urandom();
        else
            b.hscale = {1'($urandom()), 5'($urandom_range(20, 8)), 10'($urandom())};
        if ($urandom_range(9) == 0)
            b.ascale = $urandom();
        else
            b.ascale = {1'($urandom()), 8'($urandom_range(140, 105)), 23'($urandom())};
        b.last = last;
        return b;
    endfunction

    function automatic block_pair_t fixed_block(logic [7:0] wv, logic [7:0] av,
                                                logic [15:0] hs, logic [31:0] as,
                                                logic last);
        block_pair_t b;
        b.w      = {32{wv}};
        b.a      = {32{av}};
        b.hscale = hs;
        b.ascale = as;
        b.last   = last;
        return b;
    endfunction

    task automatic send_rows(int n_items);
        int sent;
        int row_len;
        sent = 0;
        while (sent < n_items)
        begin
            row_len = $urandom_range(6, 1);
            for (int k = 1; k <= row_len; k++)
                send_block(rand_block(k == row_len || $urandom_range(19) == 0));
            sent += row_len;
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // min times min, one scale each
        send_block(fixed_block(8'h80, 8'h80, 16'h3C00, 32'h3F80_0000, 1'b1));
        send_block(fixed_block(8'h7F, 8'h80, 16'h3C00, 32'h3F80_0000, 1'b1));
        send_block(fixed_block(8'h00, 8'h00, 16'h0000, 32'h0000_0000, 1'b1));
        send_block(fixed_block(8'h01, 8'hFF, 16'h8000, 32'h8000_0000, 1'b1));
        // several blocks before the last one
        send_block(fixed_block(8'h05, 8'h03, 16'h3800, 32'h4000_0000, 1'b0));
        send_block(fixed_block(8'hFB, 8'h07, 16'h3555, 32'h3DCC_CCCD, 1'b0));
        send_block(fixed_block(8'h11, 8'h22, 16'h0001, 32'h0000_0001, 1'b1));
        // subnormal half and single scales
        send_block(fixed_block(8'h7F, 8'h7F, 16'h03FF, 32'h007F_FFFF, 1'b1));
        // overflow to infinity
        send_block(fixed_block(8'h80, 8'h80, 16'h7BFF, 32'h7F7F_FFFF, 1'b1));
        send_block(fixed_block(8'h80, 8'h7F, 16'h7BFF, 32'h7F7F_FFFF, 1'b1));
        // inf times zero dot
        send_block(fixed_block(8'h00, 8'h55, 16'h7C00, 32'h3F80_0000, 1'b1));
        // inf minus inf across blocks
        send_block(fixed_block(8'h01, 8'h01, 16'h7C00, 32'h3F80_0000, 1'b0));
        send_block(fixed_block(8'h01, 8'hFF, 16'h7C00, 32'h3F80_0000, 1'b1));
        // nan scales
        send_block(fixed_block(8'h01, 8'h01, 16'h7E01, 32'h3F80_0000, 1'b1));
        send_block(fixed_block(8'h01, 8'h01, 16'h3C00, 32'hFFBF_FFFF, 1'b1));
        send_block(fixed_block(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0));
        send_block(fixed_block(8'hAA, 8'h55, 16'h5555, 32'h5555_5555, 1'b1));
        // cancellation to exact zero
        send_block(fixed_block(8'h02, 8'h03, 16'h3C00, 32'h3F80_0000, 1'b0));
        send_block(fixed_block(8'hFE, 8'h03, 16'h3C00, 32'h3F80_0000, 1'b1));
        wait_results_done();
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_rows(300);
        wait_results_done();
    endtask

    task automatic test_sender_idle();
        send_idle_pct = 63;
        stall_pct     = 0;
        send_rows(300);
        wait_results_done();
    endtask

    task automatic test_receiver_stall();
        send_idle_pct = 0;
        stall_pct     = 63;
        send_rows(300);
        wait_results_done();
    endtask

    task automatic test_both_idle();
        send_idle_pct = 27;
        stall_pct     = 27;
        send_rows(300);
        wait_results_done();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        weight_lo     = '0;
        weight_mid_lo = '0;
        weight_mid_hi = '0;
        weight_hi     = '0;
        act_lo        = '0;
        act_mid_lo    = '0;
        act_mid_hi    = '0;
        act_hi        = '0;
        weight_scale  = '0;
        act_scale     = '0;
        last_block    = 1'b0;
        acc_model     = POS_ZERO;
        fail_count    = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
src/q8dot_pkg.sv
src/q8dot_lane.sv
src/q8dot_round.sv
src/q8_0_block_dot_accumulate.sv
tb/tb_q8_0_block_dot_accumulate.sv
